/* rtl/core/assert_macros.svh */
// Assertion macros shared by the reorder buffer RTL.
// Depends on nothing; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// A condition that must hold at every clock edge out of reset.
`define RBC_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that must hold in the cycle after the trigger.
`define RBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define RBC_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define RBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

/* rtl/core/rbc_pkg.sv */
// Types and constants of the reorder buffer commit block.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package rbc_pkg;

    // Default number of buffer entries.
    localparam int DEPTH_DEF = 128;

    // Operation carried by an input item.
    typedef enum logic [1:0] {
        MODE_PUSH      = 2'd0,
        MODE_WRITEBACK = 2'd1,
        MODE_COMMIT    = 2'd2,
        MODE_FLUSH     = 2'd3
    } t_mode;

    // One input item.
    typedef struct packed {
        t_mode              mode;
        logic [15:0]        tag;
        logic [4:0]         dest_reg;
        logic               has_dest;
        logic               pending;
        logic signed [31:0] value;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic               accepted;
        logic               overflow;
        logic               commit_valid;
        logic               commit_writes;
        logic [4:0]         commit_dest;
        logic signed [31:0] commit_value;
        logic [15:0]        commit_tag;
        logic [15:0]        head_tag;
        logic               is_empty;
        logic               is_full;
    } t_out_item;

    // Fields kept in the tag memory, written only by a push.
    typedef struct packed {
        logic [15:0] tag;
        logic [4:0]  dest;
        logic        has_dest;
    } t_tag_entry;

    // Fields kept in the value memory, written by a push and by a writeback.
    typedef struct packed {
        logic               pending;
        logic signed [31:0] value;
    } t_val_entry;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_PUSH,
        S_SCAN,
        S_SCAN_END,
        S_CMT_RD,
        S_CMT_CHK,
        S_FLUSH,
        S_HEAD_RD,
        S_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic push;
        logic scan_start;
        logic scan_step;
        logic cmt_read;
        logic cmt_retire;
        logic flush;
        logic head_read;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic scan_last;
        logic out_busy;
    } t_status;

endpackage

`default_nettype wire

/* rtl/core/reorder_buffer_commit_top.sv */
// Every item ends in the head read and output states; push and flush first run their own state,
// a commit reads and checks the head entry, and a writeback scans the live entries, one buffer
// entry compared per cycle through the single tag memory read port, unless the buffer is empty.
// One item at a time; the next item is taken once the result is registered.
// Reset (synchronous, active low) empties the buffer; entry memories are not cleared.
`default_nettype none

module reorder_buffer_commit_top #(
    parameter int DEPTH = rbc_pkg::DEPTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire rbc_pkg::t_in_item i_in_item,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output rbc_pkg::t_out_item o_out_item
);

    rbc_pkg::t_cmd    cmd;
    rbc_pkg::t_status status;

    // Sequencer for one item at a time.
    rbc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_in_item.mode),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Buffer storage, pointers and result register.
    rbc_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

/* rtl/core/rbc_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
`default_nettype none

module rbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/rbc_ctrl.sv */
// Controller state machine of the reorder buffer: sequences one item at a time.
// Depends on rbc_pkg for the state, command and status types.
`default_nettype none

module rbc_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire rbc_pkg::t_mode i_mode,
    output logic                o_in_stall,
    input  wire rbc_pkg::t_status i_status,
    output rbc_pkg::t_cmd       o_cmd
);

    rbc_pkg::t_state r_state;
    rbc_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rbc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            rbc_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    case (i_mode)
                        rbc_pkg::MODE_PUSH: begin
                            n_state = rbc_pkg::S_PUSH;
                        end
                        rbc_pkg::MODE_WRITEBACK: begin
                            if (i_status.empty) begin
                                n_state = rbc_pkg::S_HEAD_RD;
                            end else begin
                                o_cmd.scan_start = 1'b1;
                                n_state          = rbc_pkg::S_SCAN;
                            end
                        end
                        rbc_pkg::MODE_COMMIT: begin
                            n_state = i_status.empty ? rbc_pkg::S_HEAD_RD
                                                     : rbc_pkg::S_CMT_RD;
                        end
                        default: begin
                            n_state = rbc_pkg::S_FLUSH;
                        end
                    endcase
                end
            end
            rbc_pkg::S_PUSH: begin
                o_cmd.push = 1'b1;
                n_state    = rbc_pkg::S_HEAD_RD;
            end
            rbc_pkg::S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_last) begin
                    n_state = rbc_pkg::S_SCAN_END;
                end
            end
            rbc_pkg::S_SCAN_END: begin
                // The compare of the last entry finishes here.
                n_state = rbc_pkg::S_HEAD_RD;
            end
            rbc_pkg::S_CMT_RD: begin
                o_cmd.cmt_read = 1'b1;
                n_state        = rbc_pkg::S_CMT_CHK;
            end
            rbc_pkg::S_CMT_CHK: begin
                o_cmd.cmt_retire = 1'b1;
                n_state          = rbc_pkg::S_HEAD_RD;
            end
            rbc_pkg::S_FLUSH: begin
                o_cmd.flush = 1'b1;
                n_state     = rbc_pkg::S_HEAD_RD;
            end
            rbc_pkg::S_HEAD_RD: begin
                o_cmd.head_read = 1'b1;
                n_state         = rbc_pkg::S_OUT;
            end
            rbc_pkg::S_OUT: begin
                if (!i_status.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = rbc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rbc_pkg::S_IDLE;
            end
        endcase
    end

    // New items are taken only between operations.
    assign o_in_stall = (r_state != rbc_pkg::S_IDLE);

endmodule

`default_nettype wire

/* rtl/core/rbc_datapath.sv */
// Datapath of the reorder buffer: pointers, entry memories, tag scan and result register.
// Depends on rbc_pkg, rbc_ram and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rbc_datapath #(
    parameter int DEPTH = rbc_pkg::DEPTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire rbc_pkg::t_cmd i_cmd,
    output rbc_pkg::t_status   o_status,
    input  wire rbc_pkg::t_in_item i_in_item,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output rbc_pkg::t_out_item o_out_item
);

    localparam int AW = $clog2(DEPTH);
    localparam int OW = $clog2(DEPTH + 1);
    localparam int TW = $bits(rbc_pkg::t_tag_entry);
    localparam int VW = $bits(rbc_pkg::t_val_entry);

    // Control registers.
    logic [AW-1:0] r_head;
    logic [AW-1:0] r_tail;
    logic [OW-1:0] r_occ;
    logic [AW-1:0] r_scan;
    logic [OW-1:0] r_cnt;
    logic          r_cmp_vld;
    logic          r_out_valid;

    // Payload registers.
    rbc_pkg::t_in_item  r_item;
    rbc_pkg::t_out_item r_res;
    rbc_pkg::t_out_item n_res;
    rbc_pkg::t_out_item r_out;
    rbc_pkg::t_out_item n_out;
    logic [AW-1:0]      r_cmp_addr;

    // Memory ports.
    logic                  tag_we;
    logic                  tag_re;
    logic [AW-1:0]         tag_raddr;
    rbc_pkg::t_tag_entry   tag_wdata;
    rbc_pkg::t_tag_entry   tag_rdata;
    logic                  val_we;
    logic [AW-1:0]         val_waddr;
    rbc_pkg::t_val_entry   val_wdata;
    rbc_pkg::t_val_entry   val_rdata;

    logic full;
    logic empty;
    logic push_ok;
    logic full_push;
    logic wb_hit;
    logic retire;

    // Step a pointer around the ring.
    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] ptr);
        logic [AW-1:0] nxt;
        nxt = (ptr == AW'(DEPTH - 1)) ? '0 : ptr + 1'b1;
        return nxt;
    endfunction

    assign full      = (r_occ == OW'(DEPTH));
    assign empty     = (r_occ == '0);
    assign push_ok   = i_cmd.push && !full;
    assign full_push = i_cmd.push && full;
    assign wb_hit    = r_cmp_vld && (tag_rdata.tag == r_item.tag);
    assign retire    = i_cmd.cmt_retire && !val_rdata.pending;

    // Tag memory: written by a push, read by the scan and at the head.
    assign tag_we          = push_ok;
    assign tag_wdata.tag   = r_item.tag;
    assign tag_wdata.dest  = r_item.dest_reg;
    assign tag_wdata.has_dest = r_item.has_dest;
    assign tag_re          = i_cmd.scan_step || i_cmd.cmt_read || i_cmd.head_read;
    assign tag_raddr       = i_cmd.scan_step ? r_scan : r_head;

    rbc_ram #(
        .WIDTH (TW),
        .DEPTH (DEPTH)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (tag_we),
        .i_waddr (r_tail),
        .i_wdata (tag_wdata),
        .i_re    (tag_re),
        .i_raddr (tag_raddr),
        .o_rdata (tag_rdata)
    );

    // Value memory: a push clears the value, a matching writeback fills it.
    assign val_we    = push_ok || wb_hit;
    assign val_waddr = wb_hit ? r_cmp_addr : r_tail;
    always_comb begin
        if (wb_hit) begin
            val_wdata.pending = 1'b0;
            val_wdata.value   = r_item.value;
        end else begin
            val_wdata.pending = r_item.pending;
            val_wdata.value   = '0;
        end
    end

    rbc_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (val_waddr),
        .i_wdata (val_wdata),
        .i_re    (i_cmd.cmt_read),
        .i_raddr (r_head),
        .o_rdata (val_rdata)
    );

    // Pointers, occupancy, scan counter and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_occ       <= '0;
            r_scan      <= '0;
            r_cnt       <= '0;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.scan_step;
            if (push_ok) begin
                r_tail <= ptr_inc(r_tail);
                r_occ  <= r_occ + 1'b1;
            end
            if (retire) begin
                r_head <= ptr_inc(r_head);
                r_occ  <= r_occ - 1'b1;
            end
            if (i_cmd.flush) begin
                r_head <= r_tail;
                r_occ  <= '0;
            end
            if (i_cmd.scan_start) begin
                r_scan <= r_head;
                r_cnt  <= '0;
            end else if (i_cmd.scan_step) begin
                r_scan <= ptr_inc(r_scan);
                r_cnt  <= r_cnt + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Per-item result flags, cleared when an item is taken.
    always_comb begin
        n_res = r_res;
        if (i_cmd.load) begin
            n_res = '0;
        end
        if (full_push) begin
            n_res.overflow = 1'b1;
        end
        if (push_ok) begin
            n_res.accepted = 1'b1;
        end
        if (retire) begin
            n_res.accepted      = 1'b1;
            n_res.commit_valid  = 1'b1;
            n_res.commit_tag    = tag_rdata.tag;
            n_res.commit_value  = val_rdata.value;
            n_res.commit_dest   = tag_rdata.has_dest ? tag_rdata.dest : '0;
            n_res.commit_writes = tag_rdata.has_dest && (tag_rdata.dest != '0);
        end
    end

    // Result with the head tag and fill flags after the operation.
    always_comb begin
        n_out          = r_res;
        n_out.head_tag = empty ? '0 : tag_rdata.tag;
        n_out.is_empty = empty;
        n_out.is_full  = full;
    end

    // Item capture, result flags and the output register.
    always_ff @(posedge i_clk) begin
        r_cmp_addr <= r_scan;
        r_res      <= n_res;
        if (i_cmd.load) begin
            r_item <= i_in_item;
        end
        if (i_cmd.out_load) begin
            r_out <= n_out;
        end
    end

    assign o_status.empty     = empty;
    assign o_status.scan_last = (OW'(r_cnt + 1'b1) == r_occ);
    assign o_status.out_busy  = r_out_valid && i_out_stall;
    assign o_out_valid        = r_out_valid;
    assign o_out_item         = r_out;

    // Checks on the buffer bookkeeping.
    `RBC_ASSERT_ALWAYS(a_occ_bound, i_clk, i_rst_n, r_occ <= OW'(DEPTH), "occupancy above depth")
    `RBC_ASSERT_NEXT(a_flush_empties, i_clk, i_rst_n, i_cmd.flush, r_occ == '0,
        "flush left entries")
    `RBC_ASSERT_NEXT(a_full_push_holds, i_clk, i_rst_n, full_push,
        $stable(r_tail) && $stable(r_occ), "push into a full buffer moved the tail")
    `RBC_ASSERT_ALWAYS(a_no_write_clash, i_clk, i_rst_n, !(wb_hit && i_cmd.push),
        "writeback and push share the value write port")
    `RBC_ASSERT_ALWAYS(a_writes_need_commit, i_clk, i_rst_n,
        !(r_out_valid && r_out.commit_writes) || r_out.commit_valid,
        "register write without a retired entry")

endmodule

`default_nettype wire

/* tb/reorder_buffer_commit_top_tb.sv */
// Self-checking testbench for the reorder buffer commit block.
// A directed table and random instruction streams are scored against an in-bench buffer model.
// Depends on rbc_pkg and reorder_buffer_commit_top.

module reorder_buffer_commit_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROB_DEPTH = rbc_pkg::DEPTH_DEF;
    localparam int ROB_AW = $clog2(ROB_DEPTH);
    localparam int unsigned RANDOM_ITEMS = 700;
    localparam int unsigned HOLD_OFF_CYCLES = 400;
    localparam int unsigned HOLD_OFF_AT = 150;

    // One row of the directed table; the result is typed in only where marked.
    typedef struct {
        rbc_pkg::t_in_item  item;
        bit                 typed;
        rbc_pkg::t_out_item result;
    } t_stim_row;

    logic               i_clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    rbc_pkg::t_in_item  in_item = '0;
    logic               out_stall = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    rbc_pkg::t_out_item o_out_item;

    // Model of the buffer: entry fields, pointers and fill level.
    logic [15:0]        rob_tag      [ROB_DEPTH];
    logic [4:0]         rob_dest     [ROB_DEPTH];
    logic               rob_has_dest [ROB_DEPTH];
    logic               rob_pending  [ROB_DEPTH];
    logic signed [31:0] rob_value    [ROB_DEPTH];
    logic [ROB_AW-1:0]  rob_head = '0;
    logic [ROB_AW-1:0]  rob_tail = '0;
    int unsigned        rob_count = 0;

    rbc_pkg::t_out_item rob_results_due[$];
    t_stim_row          directed_rows[$];
    int unsigned        mismatches = 0;
    int unsigned        items_sent = 0;
    int unsigned        send_gap_max = 16;

    reorder_buffer_commit_top #(
        .DEPTH(ROB_DEPTH)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_out_item (o_out_item)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog, well beyond the slowest correct run.
    initial begin
        #1_600_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic logic [15:0] rnd_tag();
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic logic [4:0] rnd_dest();
        return 5'($urandom_range(0, 31));
    endfunction

    function automatic logic rnd_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    // Next slot of the model ring.
    function automatic logic [ROB_AW-1:0] rob_next(input logic [ROB_AW-1:0] ptr);
        return (ptr == ROB_AW'(ROB_DEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    function automatic rbc_pkg::t_in_item mk_item(rbc_pkg::t_mode mode, logic [15:0] tag,
                                                  logic [4:0] dest, logic has_dest,
                                                  logic pending, logic [31:0] value);
        rbc_pkg::t_in_item it;
        it.mode     = mode;
        it.tag      = tag;
        it.dest_reg = dest;
        it.has_dest = has_dest;
        it.pending  = pending;
        it.value    = value;
        return it;
    endfunction

    function automatic rbc_pkg::t_out_item mk_result(logic acc, logic ovf, logic cvalid,
                                                     logic cwrites, logic [4:0] cdest,
                                                     logic [31:0] cvalue, logic [15:0] ctag,
                                                     logic [15:0] head, logic empty,
                                                     logic full);
        rbc_pkg::t_out_item r;
        r.accepted      = acc;
        r.overflow      = ovf;
        r.commit_valid  = cvalid;
        r.commit_writes = cwrites;
        r.commit_dest   = cdest;
        r.commit_value  = cvalue;
        r.commit_tag    = ctag;
        r.head_tag      = head;
        r.is_empty      = empty;
        r.is_full       = full;
        return r;
    endfunction

    // Applies one item to the buffer model and returns the result it should give.
    function automatic rbc_pkg::t_out_item predict_rob_result(rbc_pkg::t_in_item it);
        rbc_pkg::t_out_item r;
        logic [ROB_AW-1:0]  p;
        int unsigned        i;
        r = '0;
        case (it.mode)
            rbc_pkg::MODE_PUSH: begin
                if (rob_count >= ROB_DEPTH) begin
                    r.overflow = 1'b1;
                end else begin
                    rob_tag[rob_tail]      = it.tag;
                    rob_dest[rob_tail]     = it.dest_reg;
                    rob_has_dest[rob_tail] = it.has_dest;
                    rob_pending[rob_tail]  = it.pending;
                    rob_value[rob_tail]    = '0;
                    rob_tail  = rob_next(rob_tail);
                    rob_count = rob_count + 1;
                    r.accepted = 1'b1;
                end
            end
            rbc_pkg::MODE_WRITEBACK: begin
                // Only live entries, head onward, can take the value.
                p = rob_head;
                for (i = 0; i < rob_count; i++) begin
                    if (rob_tag[p] == it.tag) begin
                        rob_pending[p] = 1'b0;
                        rob_value[p]   = it.value;
                    end
                    p = rob_next(p);
                end
            end
            rbc_pkg::MODE_COMMIT: begin
                if (rob_count != 0 && !rob_pending[rob_head]) begin
                    r.accepted     = 1'b1;
                    r.commit_valid = 1'b1;
                    r.commit_tag   = rob_tag[rob_head];
                    r.commit_value = rob_value[rob_head];
                    if (rob_has_dest[rob_head]) begin
                        r.commit_dest   = rob_dest[rob_head];
                        r.commit_writes = (rob_dest[rob_head] != 5'd0);
                    end
                    rob_head  = rob_next(rob_head);
                    rob_count = rob_count - 1;
                end
            end
            default: begin
                rob_head  = rob_tail;
                rob_count = 0;
            end
        endcase
        r.head_tag = (rob_count != 0) ? rob_tag[rob_head] : 16'd0;
        r.is_empty = (rob_count == 0);
        r.is_full  = (rob_count >= ROB_DEPTH);
        return r;
    endfunction

    // Picks the tag of a live entry, the head at least half of the time.
    function automatic logic [15:0] live_tag();
        int unsigned off;
        off = $urandom_range(0, rob_count - 1);
        if ($urandom_range(0, 1) != 0) begin
            return rob_tag[rob_head];
        end
        return rob_tag[ROB_AW'((rob_head + off) % ROB_DEPTH)];
    endfunction

    // A plausible instruction stream: pushes, writebacks mostly to live tags, commits, rare flushes.
    function automatic rbc_pkg::t_in_item wellformed_item();
        int unsigned r;
        logic [15:0] tag;
        r   = $urandom_range(0, 99);
        tag = rnd_tag();
        if (r < 40) begin
            if (rob_count != 0 && $urandom_range(0, 4) == 0) begin
                tag = live_tag();
            end
            return mk_item(rbc_pkg::MODE_PUSH, tag, rnd_dest(), $urandom_range(0, 3) != 0,
                           $urandom_range(0, 3) != 0, $urandom);
        end
        if (r < 70) begin
            if (rob_count != 0 && $urandom_range(0, 4) != 0) begin
                tag = live_tag();
            end
            return mk_item(rbc_pkg::MODE_WRITEBACK, tag, rnd_dest(), rnd_bit(), rnd_bit(),
                           $urandom);
        end
        if (r < 97) begin
            return mk_item(rbc_pkg::MODE_COMMIT, tag, rnd_dest(), rnd_bit(), rnd_bit(),
                           $urandom);
        end
        return mk_item(rbc_pkg::MODE_FLUSH, tag, rnd_dest(), rnd_bit(), rnd_bit(), $urandom);
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t ns: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_result(int unsigned n, rbc_pkg::t_out_item got,
                                rbc_pkg::t_out_item want);
        if (got.accepted !== want.accepted)
            report_mismatch($sformatf("result %0d accepted %0b, expected %0b",
                                      n, got.accepted, want.accepted));
        if (got.overflow !== want.overflow)
            report_mismatch($sformatf("result %0d overflow %0b, expected %0b",
                                      n, got.overflow, want.overflow));
        if (got.commit_valid !== want.commit_valid)
            report_mismatch($sformatf("result %0d commit_valid %0b, expected %0b",
                                      n, got.commit_valid, want.commit_valid));
        if (got.commit_writes !== want.commit_writes)
            report_mismatch($sformatf("result %0d commit_writes %0b, expected %0b",
                                      n, got.commit_writes, want.commit_writes));
        if (got.commit_dest !== want.commit_dest)
            report_mismatch($sformatf("result %0d commit_dest %0d, expected %0d",
                                      n, got.commit_dest, want.commit_dest));
        if (got.commit_value !== want.commit_value)
            report_mismatch($sformatf("result %0d commit_value %h, expected %h",
                                      n, got.commit_value, want.commit_value));
        if (got.commit_tag !== want.commit_tag)
            report_mismatch($sformatf("result %0d commit_tag %h, expected %h",
                                      n, got.commit_tag, want.commit_tag));
        if (got.head_tag !== want.head_tag)
            report_mismatch($sformatf("result %0d head_tag %h, expected %h",
                                      n, got.head_tag, want.head_tag));
        if (got.is_empty !== want.is_empty)
            report_mismatch($sformatf("result %0d is_empty %0b, expected %0b",
                                      n, got.is_empty, want.is_empty));
        if (got.is_full !== want.is_full)
            report_mismatch($sformatf("result %0d is_full %0b, expected %0b",
                                      n, got.is_full, want.is_full));
    endtask

    // Offers one item after a random gap and files its expected result once taken.
    // Valid is lowered only for a gap before the item, so it never toggles within one step.
    task automatic send_item(rbc_pkg::t_in_item it, bit typed,
                             rbc_pkg::t_out_item typed_result);
        int unsigned        gap;
        rbc_pkg::t_out_item predicted;
        gap = $urandom_range(0, send_gap_max);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predicted = predict_rob_result(it);
        rob_results_due.push_back(typed ? typed_result : predicted);
        items_sent++;
        if (items_sent % 64 == 0) begin
            send_gap_max = ($urandom_range(0, 1) != 0) ? 16 : 0;
        end
    endtask

    task automatic add_row(rbc_pkg::t_in_item it, bit typed, rbc_pkg::t_out_item result);
        t_stim_row row;
        row.item   = it;
        row.typed  = typed;
        row.result = result;
        directed_rows.push_back(row);
    endtask

    // Receiver: stalls a random number of cycles per result, once for a long stretch.
    initial begin
        int unsigned stall_left;
        int unsigned taken;
        int unsigned recv_gap_max;
        stall_left   = 0;
        taken        = 0;
        recv_gap_max = 16;
        forever begin
            @(posedge i_clk);
            if (rst_n) begin
                if (o_out_valid && !out_stall) begin
                    if (rob_results_due.size() == 0) begin
                        report_mismatch($sformatf("result %0d arrived with none expected",
                                                  taken));
                    end else begin
                        check_result(taken, o_out_item, rob_results_due.pop_front());
                    end
                    taken++;
                    if (taken % 50 == 0) begin
                        recv_gap_max = ($urandom_range(0, 1) != 0) ? 16 : 0;
                    end
                    if (taken == HOLD_OFF_AT) begin
                        stall_left = HOLD_OFF_CYCLES;
                    end else begin
                        stall_left = $urandom_range(0, recv_gap_max);
                    end
                end else if (o_out_valid && stall_left != 0) begin
                    // Count the wait only while a result is actually held back.
                    stall_left--;
                end
                out_stall <= (stall_left != 0);
            end
        end
    end

    // Sender: reset, directed table, then random instruction streams.
    initial begin
        int unsigned fills;
        int unsigned kind;
        int unsigned n;

        // Directed rows: empty buffer, tag and value extremes, duplicate tags,
        // stale entries after a flush, and destination register zero.
        add_row(mk_item(rbc_pkg::MODE_COMMIT, 16'h0000, 5'd0, 1'b0, 1'b0, 32'h0), 1'b1,
                mk_result(1'b0, 1'b0, 1'b0, 1'b0, 5'd0, 32'h0, 16'h0, 16'h0, 1'b1, 1'b0));
        add_row(mk_item(rbc_pkg::MODE_WRITEBACK, 16'h0000, 5'd31, 1'b1, 1'b1, 32'h7FFF_FFFF),
                1'b1,
                mk_result(1'b0, 1'b0, 1'b0, 1'b0, 5'd0, 32'h0, 16'h0, 16'h0, 1'b1, 1'b0));
        add_row(mk_item(rbc_pkg::MODE_FLUSH, 16'hFFFF, 5'd31, 1'b1, 1'b1, 32'hFFFF_FFFF), 1'b1,
                mk_result(1'b0, 1'b0, 1'b0, 1'b0, 5'd0, 32'h0, 16'h0, 16'h0, 1'b1, 1'b0));
        add_row(mk_item(rbc_pkg::MODE_PUSH, 16'hFFFF, 5'd31, 1'b1, 1'b1, 32'hFFFF_FFFF), 1'b1,
                mk_result(1'b1, 1'b0, 1'b0, 1'b0, 5'd0, 32'h0, 16'h0, 16'hFFFF, 1'b0, 1'b0));
        add_row(mk_item(rbc_pkg::MODE_COMMIT, 16'h0000, 5'd0, 1'b0, 1'b0, 32'h0), 1'b1,
                mk_result(1'b0, 1'b0, 1'b0, 1'b0, 5'd0, 32'h0, 16'h0, 16'hFFFF, 1'b0, 1'b0));
        add_row(mk_item(rbc_pkg::MODE_WRITEBACK, 16'hFFFF, 5'd0, 1'b0, 1'b0, 32'h8000_0000),
                1'b1,
                mk_result(1'b0, 1'b0, 1'b0, 1'b0, 5'd0, 32'h0, 16'h0, 16'hFFFF, 1'b0, 1'b0));
        add_row(mk_item(rbc_pkg::MODE_COMMIT, 16'hFFFF, 5'd31, 1'b1, 1'b1, 32'h7FFF_FFFF), 1'b1,
                mk_result(1'b1, 1'b0, 1'b1, 1'b1, 5'd31, 32'h8000_0000, 16'hFFFF, 16'h0,
                          1'b1, 1'b0));
        add_row(mk_item(rbc_pkg::MODE_PUSH, 16'h0000, 5'd0, 1'b1, 1'b0, 32'h1234_5678), 1'b1,
                mk_result(1'b1, 1'b0, 1'b0, 1'b0, 5'd0, 32'h0, 16'h0, 16'h0000, 1'b0, 1'b0));
        add_row(mk_item(rbc_pkg::MODE_COMMIT, 16'h0000, 5'd0, 1'b0, 1'b0, 32'h0), 1'b1,
                mk_result(1'b1, 1'b0, 1'b1, 1'b0, 5'd0, 32'h0, 16'h0000, 16'h0, 1'b1, 1'b0));
        add_row(mk_item(rbc_pkg::MODE_PUSH, 16'h0001, 5'd5, 1'b0, 1'b1, 32'h0), 1'b0, '0);
        add_row(mk_item(rbc_pkg::MODE_PUSH, 16'h0001, 5'd17, 1'b1, 1'b1, 32'h0), 1'b0, '0);
        add_row(mk_item(rbc_pkg::MODE_WRITEBACK, 16'h0000, 5'd0, 1'b0, 1'b0, 32'h7FFF_FFFF),
                1'b0, '0);
        add_row(mk_item(rbc_pkg::MODE_WRITEBACK, 16'h0001, 5'd0, 1'b0, 1'b0, 32'h7FFF_FFFF),
                1'b0, '0);
        add_row(mk_item(rbc_pkg::MODE_COMMIT, 16'h0000, 5'd0, 1'b0, 1'b0, 32'h0), 1'b0, '0);
        add_row(mk_item(rbc_pkg::MODE_COMMIT, 16'h0000, 5'd0, 1'b0, 1'b0, 32'h0), 1'b0, '0);
        add_row(mk_item(rbc_pkg::MODE_PUSH, 16'hA5A5, 5'd3, 1'b1, 1'b1, 32'h0), 1'b0, '0);
        add_row(mk_item(rbc_pkg::MODE_FLUSH, 16'h0000, 5'd0, 1'b0, 1'b0, 32'h0), 1'b1,
                mk_result(1'b0, 1'b0, 1'b0, 1'b0, 5'd0, 32'h0, 16'h0, 16'h0, 1'b1, 1'b0));
        add_row(mk_item(rbc_pkg::MODE_WRITEBACK, 16'hA5A5, 5'd0, 1'b0, 1'b0, 32'h5555_AAAA),
                1'b1,
                mk_result(1'b0, 1'b0, 1'b0, 1'b0, 5'd0, 32'h0, 16'h0, 16'h0, 1'b1, 1'b0));
        add_row(mk_item(rbc_pkg::MODE_COMMIT, 16'h0000, 5'd0, 1'b0, 1'b0, 32'h0), 1'b1,
                mk_result(1'b0, 1'b0, 1'b0, 1'b0, 5'd0, 32'h0, 16'h0, 16'h0, 1'b1, 1'b0));
        add_row(mk_item(rbc_pkg::MODE_PUSH, 16'h5A5A, 5'd31, 1'b1, 1'b0, 32'hAAAA_5555), 1'b1,
                mk_result(1'b1, 1'b0, 1'b0, 1'b0, 5'd0, 32'h0, 16'h0, 16'h5A5A, 1'b0, 1'b0));
        add_row(mk_item(rbc_pkg::MODE_COMMIT, 16'h0000, 5'd0, 1'b0, 1'b0, 32'h0), 1'b0, '0);

        repeat (3) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            send_item(directed_rows[k].item, directed_rows[k].typed, directed_rows[k].result);
        end

        // Random part: mostly plausible streams, some noise, and up to two runs that
        // fill the buffer, push past full, then commit some entries and maybe flush.
        fills = 0;
        while (items_sent < directed_rows.size() + RANDOM_ITEMS) begin
            kind = $urandom_range(0, 7);
            if (kind == 0 && fills < 2) begin
                fills++;
                while (rob_count < ROB_DEPTH) begin
                    send_item(mk_item(rbc_pkg::MODE_PUSH, rnd_tag(), rnd_dest(), rnd_bit(),
                                      $urandom_range(0, 2) != 0, $urandom), 1'b0, '0);
                end
                repeat ($urandom_range(1, 3)) begin
                    send_item(mk_item(rbc_pkg::MODE_PUSH, rnd_tag(), rnd_dest(), rnd_bit(),
                                      rnd_bit(), $urandom), 1'b0, '0);
                end
                n = $urandom_range(4, 16);
                repeat (n) begin
                    send_item(mk_item(rbc_pkg::MODE_WRITEBACK, rob_tag[rob_head], rnd_dest(),
                                      rnd_bit(), rnd_bit(), $urandom), 1'b0, '0);
                    send_item(mk_item(rbc_pkg::MODE_COMMIT, rnd_tag(), rnd_dest(), rnd_bit(),
                                      rnd_bit(), $urandom), 1'b0, '0);
                end
                if ($urandom_range(0, 1) != 0) begin
                    send_item(mk_item(rbc_pkg::MODE_FLUSH, rnd_tag(), rnd_dest(), rnd_bit(),
                                      rnd_bit(), $urandom), 1'b0, '0);
                end
            end else if (kind == 1) begin
                repeat (10) begin
                    send_item(mk_item(rbc_pkg::t_mode'($urandom_range(0, 3)), rnd_tag(),
                                      rnd_dest(), rnd_bit(), rnd_bit(), $urandom), 1'b0, '0);
                end
            end else begin
                repeat (24) send_item(wellformed_item(), 1'b0, '0);
            end
        end
        in_valid <= 1'b0;

        // Drain, then allow for one full scan in case of a stray result.
        while (rob_results_due.size() != 0) @(posedge i_clk);
        repeat (ROB_DEPTH + 16) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/rbc_pkg.sv
rtl/core/rbc_ram.sv
rtl/core/rbc_ctrl.sv
rtl/core/rbc_datapath.sv
rtl/core/reorder_buffer_commit_top.sv
tb/reorder_buffer_commit_top_tb.sv
